// ===== design/tlpq_pkg.sv =====
// shared types and codes for the two-level priority queue pair
package tlpq_pkg;

  localparam logic       CMD_ENQ = 1'b0;
  localparam logic       CMD_DEQ = 1'b1;

  localparam logic [1:0] QSEL_HIGH = 2'd0;
  localparam logic [1:0] QSEL_LOW  = 2'd1;

  localparam int unsigned STATUS_W = 3;
  localparam int unsigned WORD_W   = 32;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BLOCKED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOQUEUE = 3'd4;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ctl_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;    // take the input transfer, update pointers, start store read
    logic load_out;  // move the finished result into the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_full;
  } dp_stat_t;

endpackage

// ===== design/tlpq_ctrl.sv =====
// controller: sequences accept, store read and result hand-off
module tlpq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               out_tready,
  input  tlpq_pkg::dp_stat_t stat,
  output tlpq_pkg::dp_cmd_t  cmd
);

  tlpq_pkg::ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlpq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    in_tready    = 1'b0;
    cmd.accept   = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      tlpq_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = tlpq_pkg::S_EXEC;
        end
      end
      tlpq_pkg::S_EXEC: begin
        // wait here while the output register still holds an untaken result
        if (!stat.out_full || out_tready) begin
          cmd.load_out = 1'b1;
          state_nxt    = tlpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tlpq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/tlpq_dp.sv =====
// datapath: queue stores, front and count registers, decision and output register
module tlpq_dp #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  tlpq_pkg::dp_cmd_t                        cmd,
  output tlpq_pkg::dp_stat_t                       stat,
  input  logic                                     in_cmd,
  input  logic [1:0]                               in_sel,
  input  logic signed [tlpq_pkg::WORD_W-1:0]       in_word,
  input  logic                                     out_tready,
  output logic                                     out_tvalid,
  output logic [tlpq_pkg::STATUS_W-1:0]            out_status,
  output logic signed [tlpq_pkg::WORD_W-1:0]       out_word
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);

  logic [tlpq_pkg::WORD_W-1:0] high_mem [QUEUE_DEPTH];
  logic [tlpq_pkg::WORD_W-1:0] low_mem  [QUEUE_DEPTH];

  logic [PTR_W-1:0] hf_r, hf_nxt, lf_r, lf_nxt;
  logic [CNT_W-1:0] hc_r, hc_nxt, lc_r, lc_nxt;

  logic [tlpq_pkg::STATUS_W-1:0] st_r, st_nxt;
  logic                          pop_r, pop_nxt;
  logic                          psel_r, psel_nxt;
  logic [tlpq_pkg::WORD_W-1:0]   hrd_r, lrd_r;

  logic                          out_valid_r, out_valid_nxt;
  logic [tlpq_pkg::STATUS_W-1:0] out_status_r;
  logic [tlpq_pkg::WORD_W-1:0]   out_word_r;

  logic [SUM_W-1:0] h_rear, l_rear;
  logic             h_wr, l_wr;
  logic [PTR_W-1:0] h_waddr, l_waddr;

  assign h_rear  = SUM_W'(hf_r) + SUM_W'(hc_r);
  assign l_rear  = SUM_W'(lf_r) + SUM_W'(lc_r);
  assign h_waddr = h_rear[PTR_W-1:0];
  assign l_waddr = l_rear[PTR_W-1:0];

  always_comb begin
    st_nxt   = tlpq_pkg::ST_OK;
    pop_nxt  = 1'b0;
    psel_nxt = 1'b0;
    hf_nxt   = hf_r;
    hc_nxt   = hc_r;
    lf_nxt   = lf_r;
    lc_nxt   = lc_r;
    h_wr     = 1'b0;
    l_wr     = 1'b0;
    if (in_sel != tlpq_pkg::QSEL_HIGH && in_sel != tlpq_pkg::QSEL_LOW) begin
      st_nxt = tlpq_pkg::ST_NOQUEUE;
    end else if (in_cmd == tlpq_pkg::CMD_ENQ) begin
      if (in_sel == tlpq_pkg::QSEL_HIGH) begin
        if (h_rear >= DEPTH_S) begin
          st_nxt = tlpq_pkg::ST_FULL;
        end else begin
          h_wr   = 1'b1;
          hc_nxt = hc_r + CNT_W'(1);
        end
      end else begin
        if (l_rear >= DEPTH_S) begin
          st_nxt = tlpq_pkg::ST_FULL;
        end else begin
          l_wr   = 1'b1;
          lc_nxt = lc_r + CNT_W'(1);
        end
      end
    end else if (in_sel == tlpq_pkg::QSEL_HIGH) begin
      if (hc_r == '0) begin
        st_nxt = tlpq_pkg::ST_EMPTY;
      end else begin
        pop_nxt = 1'b1;
        // taking the last word rewinds the queue to slot zero
        if (hc_r == CNT_W'(1)) begin
          hf_nxt = '0;
          hc_nxt = '0;
        end else begin
          hf_nxt = hf_r + PTR_W'(1);
          hc_nxt = hc_r - CNT_W'(1);
        end
      end
    end else begin
      if (lc_r == '0) begin
        st_nxt = tlpq_pkg::ST_EMPTY;
      end else if (hc_r != '0) begin
        st_nxt = tlpq_pkg::ST_BLOCKED;
      end else begin
        pop_nxt  = 1'b1;
        psel_nxt = 1'b1;
        if (lc_r == CNT_W'(1)) begin
          lf_nxt = '0;
          lc_nxt = '0;
        end else begin
          lf_nxt = lf_r + PTR_W'(1);
          lc_nxt = lc_r - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hf_r <= '0;
      hc_r <= '0;
      lf_r <= '0;
      lc_r <= '0;
    end else if (cmd.accept) begin
      hf_r <= hf_nxt;
      hc_r <= hc_nxt;
      lf_r <= lf_nxt;
      lc_r <= lc_nxt;
    end
  end

  // stores: one write and one registered read each
  always_ff @(posedge clk) begin
    if (cmd.accept && h_wr) begin
      high_mem[h_waddr] <= in_word;
    end
    if (cmd.accept) begin
      hrd_r <= high_mem[hf_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && l_wr) begin
      low_mem[l_waddr] <= in_word;
    end
    if (cmd.accept) begin
      lrd_r <= low_mem[lf_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      st_r   <= st_nxt;
      pop_r  <= pop_nxt;
      psel_r <= psel_nxt;
    end
  end

  assign out_valid_nxt = cmd.load_out | (out_valid_r & ~out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= st_r;
      if (pop_r) begin
        out_word_r <= psel_r ? lrd_r : hrd_r;
      end else begin
        out_word_r <= '0;
      end
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_status    = out_status_r;
  assign out_word      = out_word_r;
  assign stat.out_full = out_valid_r;

  a_high_bound: assert property (@(posedge clk) disable iff (!rst_n)
    h_rear <= DEPTH_S)
    else $error("high queue rear beyond last slot");

  a_low_bound: assert property (@(posedge clk) disable iff (!rst_n)
    l_rear <= DEPTH_S)
    else $error("low queue rear beyond last slot");

  a_empty_rewind: assert property (@(posedge clk) disable iff (!rst_n)
    (hc_r != '0 || hf_r == '0) && (lc_r != '0 || lf_r == '0))
    else $error("empty queue front not rewound");

  a_word_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r != '0) |-> out_status_r == tlpq_pkg::ST_OK)
    else $error("nonzero word with error status");

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_tready))
    else $error("result overwrote an untaken result");

endmodule

// ===== design/two_level_priority_queue_pair_core.sv =====
// top level of the two-level priority queue pair
//
// Two linear (non-circular) queues of QUEUE_DEPTH words: high priority (queue 0)
// and low priority (queue 1). Each input transfer is one command: in_tuser[0]
// selects enqueue (0) or dequeue (1), in_tuser[2:1] names the queue, in_tdata
// carries the word to enqueue. Every command yields exactly one result transfer:
// out_tuser holds the status (ok, full, empty, blocked by high queue, no such
// queue) and out_tdata the dequeued word on a successful dequeue, else zero.
// An enqueue is refused once the rear has passed the last slot; a queue rewinds to
// slot zero when its last word is taken. A low dequeue is refused as blocked
// while the high queue holds a word.
// Each command is accepted in the idle state, which updates the pointers and
// starts the registered store read; the execute state then moves the result
// into the output register and raises out_tvalid, and only then is in_tready
// high again. A result waiting in the output register holds the block in the
// execute state until out_tready frees it; in_tready stays low meanwhile.
// Reset (rst_n low, synchronous) empties both queues and drops out_tvalid;
// store contents are not cleared and need no clearing pass.
module two_level_priority_queue_pair_core #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] data_in
  input  logic [2:0]  in_tuser,   // [0] cmd, [2:1] queue_sel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] data_out
  output logic [2:0]  out_tuser   // [2:0] status
);

  tlpq_pkg::dp_cmd_t  cmd;
  tlpq_pkg::dp_stat_t stat;

  tlpq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  tlpq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_cmd     (in_tuser[0]),
    .in_sel     (in_tuser[2:1]),
    .in_word    (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_status (out_tuser),
    .out_word   (out_tdata)
  );

endmodule
